@@ src/wcle_pkg.sv @@
// wcle_pkg: shared constants and types for the cell line encoder
// no dependencies; imported by the encoder top level and its checker
`default_nettype none

package wcle_pkg;

    localparam int BYTES_PER_LED = 4;
    localparam int BITS_PER_LED  = BYTES_PER_LED * 8;
    localparam int BIT_IDX_W     = 5;
    localparam logic [BIT_IDX_W-1:0] BIT_WRAP = BIT_IDX_W'(BITS_PER_LED % 32);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COLOR_W    = 32;
    localparam int CNT_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ON_COLOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_COLOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEDS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd5;

    localparam logic [CNT_W-1:0] LEDS_RST      = 8'd1;
    localparam logic [CNT_W-1:0] ZERO_HIGH_RST = 8'd35;
    localparam logic [CNT_W-1:0] ONE_HIGH_RST  = 8'd90;
    localparam logic [CNT_W-1:0] PERIOD_RST    = 8'd125;

    typedef struct packed {
        logic line_level;
        logic cell_taken;
        logic busy_res;
        logic frame_done;
    } result_t;

endpackage

`default_nettype wire

@@ src/ws2812_cell_line_encoder.sv @@
// ws2812_cell_line_encoder: serial LED line encoder, one input word per clock tick
// depends on wcle_pkg
//
// usage
//   s_ channel: one word per timer tick, carrying cell_valid, cell_on, cell_last.
//   m_ channel: one result word per input word: line_level, cell_taken,
//   busy_res, frame_done, in the same order as the inputs.
//   cfg port: cfg_wr_en, cfg_index, cfg_wdata; colours, LEDs per cell and
//   bit timing, written while no words are in flight.
// timing
//   the encoder state and the result register update at the edge that takes
//   the input word; the result is offered on m_ once results ahead of it are taken.
//   one word is taken per cycle while the result side keeps up; the limit is
//   the single state update per tick.
// stalls
//   results queue in a two-entry output buffer; s_ready drops only when both
//   entries are full, and comes back the cycle after a result is taken.
// reset
//   aresetn (synchronous, active low) empties the buffer, stops any cell in
//   progress and loads the default configuration.
`default_nettype none

module ws2812_cell_line_encoder
    import wcle_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_cell_valid,
    input  wire logic                  s_cell_on,
    input  wire logic                  s_cell_last,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_line_level,
    output logic                       m_cell_taken,
    output logic                       m_busy_res,
    output logic                       m_frame_done
);

    logic [COLOR_W-1:0] on_color_reg;
    logic [COLOR_W-1:0] off_color_reg;
    logic [CNT_W-1:0]   leds_cfg_reg;
    logic [CNT_W-1:0]   zero_high_reg;
    logic [CNT_W-1:0]   one_high_reg;
    logic [CNT_W-1:0]   period_reg;

    logic                 active_reg,       active_next;
    logic [COLOR_W-1:0]   shift_color_reg,  shift_color_next;
    logic [COLOR_W-1:0]   held_color_reg,   held_color_next;
    logic [BIT_IDX_W-1:0] bit_index_reg,    bit_index_next;
    logic [CNT_W-1:0]     leds_left_reg,    leds_left_next;
    logic [CNT_W-1:0]     tick_count_reg,   tick_count_next;
    logic                 last_pending_reg, last_pending_next;

    result_t res;
    result_t buf0_reg, buf0_next;
    result_t buf1_reg, buf1_next;
    logic [1:0] fill_reg, fill_next;

    logic push;
    logic pop;

    logic [CNT_W-1:0]     high_ticks;
    logic                 period_end;
    logic [BIT_IDX_W-1:0] bit_inc;
    logic [CNT_W-1:0]     leds_dec;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            on_color_reg  <= '0;
            off_color_reg <= '0;
            leds_cfg_reg  <= LEDS_RST;
            zero_high_reg <= ZERO_HIGH_RST;
            one_high_reg  <= ONE_HIGH_RST;
            period_reg    <= PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ON_COLOR:  on_color_reg  <= cfg_wdata[COLOR_W-1:0];
                CFG_OFF_COLOR: off_color_reg <= cfg_wdata[COLOR_W-1:0];
                CFG_LEDS:      leds_cfg_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_ZERO_HIGH: zero_high_reg <= cfg_wdata[CNT_W-1:0];
                CFG_ONE_HIGH:  one_high_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_PERIOD:    period_reg    <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign push = s_valid && s_ready;
    assign pop  = m_valid && m_ready;

    assign high_ticks = shift_color_reg[COLOR_W-1] ? one_high_reg : zero_high_reg;
    assign period_end = ({1'b0, tick_count_reg} + 9'd1) >= {1'b0, period_reg};
    assign bit_inc    = bit_index_reg + 1'b1;
    assign leds_dec   = leds_left_reg - 1'b1;

    // one tick of the encoder
    always_comb begin
        active_next       = active_reg;
        shift_color_next  = shift_color_reg;
        held_color_next   = held_color_reg;
        bit_index_next    = bit_index_reg;
        leds_left_next    = leds_left_reg;
        tick_count_next   = tick_count_reg;
        last_pending_next = last_pending_reg;
        res               = '0;

        if (!active_reg) begin
            if (s_cell_valid) begin
                res.cell_taken    = 1'b1;
                held_color_next   = s_cell_on ? on_color_reg : off_color_reg;
                shift_color_next  = s_cell_on ? on_color_reg : off_color_reg;
                bit_index_next    = '0;
                leds_left_next    = (leds_cfg_reg == '0) ? LEDS_RST : leds_cfg_reg;
                tick_count_next   = '0;
                last_pending_next = s_cell_last;
                active_next       = 1'b1;
            end
        end else begin
            res.line_level = tick_count_reg < high_ticks;
            if (period_end) begin
                tick_count_next  = '0;
                shift_color_next = {shift_color_reg[COLOR_W-2:0], 1'b0};
                bit_index_next   = bit_inc;
                if (bit_inc == BIT_WRAP) begin
                    bit_index_next = '0;
                    leds_left_next = leds_dec;
                    if (leds_dec == '0) begin
                        active_next       = 1'b0;
                        res.frame_done    = last_pending_reg;
                        last_pending_next = 1'b0;
                    end else begin
                        shift_color_next = held_color_reg;
                    end
                end
            end else begin
                tick_count_next = tick_count_reg + 1'b1;
            end
        end
        res.busy_res = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg       <= 1'b0;
            shift_color_reg  <= '0;
            held_color_reg   <= '0;
            bit_index_reg    <= '0;
            leds_left_reg    <= '0;
            tick_count_reg   <= '0;
            last_pending_reg <= 1'b0;
        end else if (push) begin
            active_reg       <= active_next;
            shift_color_reg  <= shift_color_next;
            held_color_reg   <= held_color_next;
            bit_index_reg    <= bit_index_next;
            leds_left_reg    <= leds_left_next;
            tick_count_reg   <= tick_count_next;
            last_pending_reg <= last_pending_next;
        end
    end

    // two-entry result buffer, head in buf0
    always_comb begin
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
        if (pop) begin
            if (fill_reg == 2'd2) begin
                buf0_next = buf1_reg;
            end else if (push) begin
                buf0_next = res;
            end
        end else if (push) begin
            if (fill_reg == 2'd0) begin
                buf0_next = res;
            end else begin
                buf1_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

    assign s_ready      = fill_reg != 2'd2;
    assign m_valid      = fill_reg != 2'd0;
    assign m_line_level = buf0_reg.line_level;
    assign m_cell_taken = buf0_reg.cell_taken;
    assign m_busy_res   = buf0_reg.busy_res;
    assign m_frame_done = buf0_reg.frame_done;

endmodule

`default_nettype wire

@@ src/wcle_checker.sv @@
// wcle_checker: port-level checks for ws2812_cell_line_encoder
// depends on wcle_pkg; bound to the top level at the end of this file
`default_nettype none

module wcle_checker
    import wcle_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic                  m_line_level,
    input wire logic                  m_cell_taken,
    input wire logic                  m_busy_res,
    input wire logic                  m_frame_done
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_level) && $stable(m_cell_taken)
            && $stable(m_busy_res) && $stable(m_frame_done))
        else $error("stalled result word changed");

    // back-pressure only when results are waiting
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // a taken cell starts busy with the line low
    a_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cell_taken |-> m_busy_res && !m_line_level && !m_frame_done)
        else $error("bad result on cell acceptance");

    // frame end leaves the encoder idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> !m_busy_res)
        else $error("frame done while still busy");

endmodule

bind ws2812_cell_line_encoder wcle_checker u_wcle_checker (.*);

`default_nettype wire

@@ tb/wcle_line_checker.sv @@
// wcle_line_checker: predicts the encoder line result for every accepted input word
// and compares each taken result word with the oldest prediction
// depends on wcle_pkg; instantiated beside the encoder by ws2812_cell_line_encoder_test
module wcle_line_checker
    import wcle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_cell_valid,
    input  logic                  s_cell_on,
    input  logic                  s_cell_last,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_line_level,
    input  logic                  m_cell_taken,
    input  logic                  m_busy_res,
    input  logic                  m_frame_done,
    output int                    mismatch_count,
    output int                    words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic [COLOR_W-1:0]   lit_color;
    logic [COLOR_W-1:0]   dark_color;
    logic [CNT_W-1:0]     leds_cfg;
    logic [CNT_W-1:0]     zero_hi;
    logic [CNT_W-1:0]     one_hi;
    logic [CNT_W-1:0]     bit_period;

    logic                 sending;
    logic [COLOR_W-1:0]   shift_reg;
    logic [COLOR_W-1:0]   cell_color;
    logic [BIT_IDX_W-1:0] bit_pos;
    logic [CNT_W-1:0]     leds_remaining;
    logic [CNT_W-1:0]     tick;
    logic                 frame_end_pending;

    result_t              expected_line[$];
    int                   errors;
    int                   words_checked;

    initial begin
        mismatch_count = 0;
        words_due      = 0;
        errors         = 0;
        words_checked  = 0;
    end

    task automatic clear_encoder();
        lit_color         = '0;
        dark_color        = '0;
        leds_cfg          = LEDS_RST;
        zero_hi           = ZERO_HIGH_RST;
        one_hi            = ONE_HIGH_RST;
        bit_period        = PERIOD_RST;
        sending           = 1'b0;
        shift_reg         = '0;
        cell_color        = '0;
        bit_pos           = '0;
        leds_remaining    = '0;
        tick              = '0;
        frame_end_pending = 1'b0;
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ON_COLOR:  lit_color  = data[COLOR_W-1:0];
            CFG_OFF_COLOR: dark_color = data[COLOR_W-1:0];
            CFG_LEDS:      leds_cfg   = data[CNT_W-1:0];
            CFG_ZERO_HIGH: zero_hi    = data[CNT_W-1:0];
            CFG_ONE_HIGH:  one_hi     = data[CNT_W-1:0];
            CFG_PERIOD:    bit_period = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // one timer tick of the encoder
    task automatic step_line_timer(input logic cv, input logic on, input logic last,
                                   output result_t r);
        logic [CNT_W-1:0] high_len;
        r = '0;
        if (!sending) begin
            if (cv) begin
                r.cell_taken      = 1'b1;
                cell_color        = on ? lit_color : dark_color;
                shift_reg         = cell_color;
                bit_pos           = '0;
                leds_remaining    = (leds_cfg == '0) ? CNT_W'(1) : leds_cfg;
                tick              = '0;
                frame_end_pending = last;
                sending           = 1'b1;
            end
        end else begin
            high_len     = shift_reg[COLOR_W-1] ? one_hi : zero_hi;
            r.line_level = (tick < high_len);
            if ({1'b0, tick} + 9'd1 >= {1'b0, bit_period}) begin
                tick      = '0;
                shift_reg = shift_reg << 1;
                bit_pos   = bit_pos + 1'b1;
                if (bit_pos == BIT_WRAP) begin
                    bit_pos        = '0;
                    leds_remaining = leds_remaining - 1'b1;
                    if (leds_remaining == '0) begin
                        sending           = 1'b0;
                        r.frame_done      = frame_end_pending;
                        frame_end_pending = 1'b0;
                    end else begin
                        shift_reg = cell_color;
                    end
                end
            end else begin
                tick = tick + 1'b1;
            end
        end
        r.busy_res = sending;
    endtask

    always @(posedge aclk) begin
        result_t predicted;
        result_t got;
        result_t want;
        if (!aresetn) begin
            clear_encoder();
            expected_line.delete();
        end else begin
            if (cfg_wr_en)
                write_setting(cfg_index, cfg_wdata);
            if (s_valid && s_ready) begin
                step_line_timer(s_cell_valid, s_cell_on, s_cell_last, predicted);
                expected_line.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                got.line_level = m_line_level;
                got.cell_taken = m_cell_taken;
                got.busy_res   = m_busy_res;
                got.frame_done = m_frame_done;
                if (expected_line.size() == 0) begin
                    if (errors < REPORT_LIMIT)
                        $display("%0t: result word %0d with nothing expected: level=%0b taken=%0b busy=%0b done=%0b",
                                 $realtime, words_checked, got.line_level, got.cell_taken,
                                 got.busy_res, got.frame_done);
                    errors++;
                end else begin
                    want = expected_line.pop_front();
                    if (got.line_level !== want.line_level || got.cell_taken !== want.cell_taken
                        || got.busy_res !== want.busy_res || got.frame_done !== want.frame_done)
                    begin
                        if (errors < REPORT_LIMIT)
                            $display("%0t: word %0d expected level=%0b taken=%0b busy=%0b done=%0b, got level=%0b taken=%0b busy=%0b done=%0b",
                                     $realtime, words_checked, want.line_level,
                                     want.cell_taken, want.busy_res, want.frame_done,
                                     got.line_level, got.cell_taken, got.busy_res,
                                     got.frame_done);
                        errors++;
                    end
                end
                words_checked++;
            end
        end
        words_due      <= expected_line.size();
        mismatch_count <= errors;
    end

endmodule

@@ tb/ws2812_cell_line_encoder_test.sv @@
// ws2812_cell_line_encoder_test: drives cell words and settings into the encoder,
// throttles the result side and gives the verdict
// depends on wcle_pkg, ws2812_cell_line_encoder and wcle_line_checker
module ws2812_cell_line_encoder_test
    import wcle_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int TOTAL_WORDS    = 1850;
    localparam int SLOW_WORDS     = 60;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_CYCLES     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_cell_valid;
    logic                  s_cell_on;
    logic                  s_cell_last;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_line_level;
    logic                  m_cell_taken;
    logic                  m_busy_res;
    logic                  m_frame_done;

    int                    mismatch_count;
    int                    words_due;
    int                    words_sent;
    int                    idle_cycles;
    bit                    calm;
    bit                    hold_req;

    ws2812_cell_line_encoder DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_valid (s_cell_valid),
        .s_cell_on    (s_cell_on),
        .s_cell_last  (s_cell_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_level (m_line_level),
        .m_cell_taken (m_cell_taken),
        .m_busy_res   (m_busy_res),
        .m_frame_done (m_frame_done)
    );

    wcle_line_checker line_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cell_valid   (s_cell_valid),
        .s_cell_on      (s_cell_on),
        .s_cell_last    (s_cell_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_level   (m_line_level),
        .m_cell_taken   (m_cell_taken),
        .m_busy_res     (m_busy_res),
        .m_frame_done   (m_frame_done),
        .mismatch_count (mismatch_count),
        .words_due      (words_due)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [COLOR_W-1:0] on_c, input logic [COLOR_W-1:0] off_c,
                                 input logic [CNT_W-1:0] leds, input logic [CNT_W-1:0] zero_h,
                                 input logic [CNT_W-1:0] one_h, input logic [CNT_W-1:0] per);
        write_reg(CFG_ON_COLOR, on_c);
        write_reg(CFG_OFF_COLOR, off_c);
        write_reg(CFG_LEDS, CFG_DATA_W'(leds));
        write_reg(CFG_ZERO_HIGH, CFG_DATA_W'(zero_h));
        write_reg(CFG_ONE_HIGH, CFG_DATA_W'(one_h));
        write_reg(CFG_PERIOD, CFG_DATA_W'(per));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_word(input logic cv, input logic on, input logic last);
        s_valid      <= 1'b1;
        s_cell_valid <= cv;
        s_cell_on    <= on;
        s_cell_last  <= last;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic sender_pause();
        int k;
        k = pick_gap();
        if (k > 0) begin
            s_valid <= 1'b0;
            repeat (k) @(posedge aclk);
        end
    endtask

    // hold the sender until every predicted result word has been taken
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_due != 0)
            @(posedge aclk);
    endtask

    task automatic run_settings_phase(input int n_words, input bit slow);
        logic [CNT_W-1:0] per;
        logic [CNT_W-1:0] leds;
        logic [CNT_W-1:0] zero_h;
        logic [CNT_W-1:0] one_h;
        int r;
        if (slow) begin
            per  = 8'd255;
            leds = 8'd255;
        end else begin
            r   = $urandom_range(0, 9);
            per = (r < 1) ? CNT_W'($urandom_range(0, 1))
                : (r < 9) ? CNT_W'($urandom_range(2, 4)) : CNT_W'($urandom_range(5, 12));
            r    = $urandom_range(0, 9);
            leds = (r < 7) ? 8'd1 : (r < 8) ? 8'd0 : CNT_W'($urandom_range(2, 3));
        end
        zero_h = ($urandom_range(0, 9) == 0) ? 8'd255 : CNT_W'($urandom_range(0, per + 1));
        one_h  = ($urandom_range(0, 9) == 0) ? 8'd255 : CNT_W'($urandom_range(0, per + 1));
        load_settings(pick_color(), pick_color(), leds, zero_h, one_h, per);
        repeat (n_words) begin
            send_word($urandom_range(0, 99) < 60, 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0);
            sender_pause();
        end
        drain();
    endtask

    // result side: random stalls, plus one long hold-off when asked
    initial begin
        int off;
        int on_run;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            off = pick_gap();
            if (hold_req) begin
                off += LONG_HOLD;
                hold_req = 1'b0;
            end
            if (off > 0) begin
                m_ready <= 1'b0;
                repeat (off) @(posedge aclk);
            end
            m_ready <= 1'b1;
            on_run = $urandom_range(1, 16);
            repeat (on_run) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int phase;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_cell_valid = 1'b0;
        s_cell_on    = 1'b0;
        s_cell_last  = 1'b0;
        words_sent   = 0;
        idle_cycles  = 0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no leds treated as one, zero-length and full-length pulses, one-tick bits
        load_settings('1, '0, 8'd0, 8'd0, 8'd255, 8'd0);
        send_word(1'b0, 1'b0, 1'b0);
        send_word(1'b0, 1'b1, 1'b1);
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b1, 1'b0, 1'b0);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b0, 1'b1, 1'b1);
        send_word(1'b1, 1'b0, 1'b1);
        send_word(1'b0, 1'b0, 1'b0);
        drain();

        // settings change mid-cell, spare index must be ignored
        write_reg(CFG_SPARE, '1);
        load_settings('0, '1, 8'd255, 8'd255, 8'd0, 8'd1);
        send_word(1'b1, 1'b0, 1'b1);
        send_word(1'b0, 1'b0, 1'b0);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b0, 1'b1, 1'b0);
        send_word(1'b1, 1'b0, 1'b0);
        send_word(1'b0, 1'b0, 1'b1);
        send_word(1'b1, 1'b1, 1'b1);
        drain();

        load_settings(32'hA5C3_0F96, 32'h5A3C_F069, 8'd2, 8'd1, 8'd2, 8'd3);
        send_word(1'b1, 1'b1, 1'b1);
        send_word(1'b0, 1'b0, 1'b0);
        send_word(1'b1, 1'b0, 1'b0);
        send_word(1'b0, 1'b1, 1'b1);
        send_word(1'b1, 1'b1, 1'b0);
        send_word(1'b1, 1'b0, 1'b1);
        send_word(1'b0, 1'b0, 1'b0);
        send_word(1'b0, 1'b0, 1'b0);
        drain();

        phase = 0;
        while (words_sent < TOTAL_WORDS - SLOW_WORDS) begin
            calm     = (phase % 4 == 1) || (phase == 2);
            hold_req = (phase == 2);
            run_settings_phase($urandom_range(100, 180), 1'b0);
            phase++;
        end
        calm = 1'b0;
        run_settings_phase(SLOW_WORDS, 1'b1);

        repeat (END_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && words_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/wcle_pkg.sv
src/ws2812_cell_line_encoder.sv
src/wcle_checker.sv
tb/wcle_line_checker.sv
tb/ws2812_cell_line_encoder_test.sv
